// ===== rtl/core/lap3_pkg.sv =====
package lap3_pkg;

    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int WIN_TAPS    = 9;
    localparam int CENTRE_TAP  = 4;
    localparam int COORD_W     = 10;
    localparam int SUM_W       = 11;
    localparam int DIFF_W      = 12;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int MIN_DIM     = 3;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CHAN-1:0] rgb_t;
    typedef rgb_t [WIN_TAPS-1:0] window_t;
    typedef chan_t [WIN_TAPS-1:0] taps_t;

    typedef struct packed {
        logic               produce;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } meta_t;

    typedef struct packed {
        rgb_t               pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } result_t;

endpackage

// ===== rtl/core/lap3_line_buffer.sv =====
module lap3_line_buffer
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic [$clog2(MAX_WIDTH)-1:0] col,
    input  rgb_t                         pixel,
    input  meta_t                        meta_in,
    output logic                         win_valid,
    output meta_t                        win_meta,
    output window_t                      window
);

    localparam int AW = $clog2(MAX_WIDTH);

    rgb_t          upper_mem  [MAX_WIDTH];
    rgb_t          middle_mem [MAX_WIDTH];

    rgb_t          upper_rd_reg;
    rgb_t          middle_rd_reg;
    rgb_t          pix_reg;
    logic [AW-1:0] wr_col_reg;
    meta_t         meta_reg;
    logic          s1_valid_reg;
    logic          win_valid_reg;
    meta_t         win_meta_reg;
    window_t       window_reg;
    window_t       window_next;

    // read on transfer, write back in the following cycle at the same column
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upper_rd_reg  <= upper_mem[col];
            middle_rd_reg <= middle_mem[col];
            pix_reg       <= pixel;
            wr_col_reg    <= col;
            meta_reg      <= meta_in;
        end
        if (s1_valid_reg)
        begin
            upper_mem[wr_col_reg]  <= middle_rd_reg;
            middle_mem[wr_col_reg] <= pix_reg;
            win_meta_reg           <= meta_reg;
        end
    end

    always_comb
    begin
        window_next = window_reg;
        for (int y = 0; y < 3; y++)
        begin
            window_next[y*3]     = window_reg[y*3 + 1];
            window_next[y*3 + 1] = window_reg[y*3 + 2];
        end
        window_next[2] = upper_rd_reg;
        window_next[5] = middle_rd_reg;
        window_next[8] = pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= take;
            win_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                window_reg <= window_next;
            end
        end
    end

    assign win_valid = win_valid_reg;
    assign win_meta  = win_meta_reg;
    assign window    = window_reg;

endmodule

// ===== rtl/core/lap3_lane.sv =====
module lap3_lane
    import lap3_pkg::*;
(
    input  logic  clk,
    input  taps_t taps,
    output chan_t result
);

    logic [SUM_W-1:0]  nsum_reg;
    logic [SUM_W-1:0]  nsum_next;
    chan_t             centre_reg;
    chan_t             result_reg;
    chan_t             result_next;
    logic signed [DIFF_W-1:0] diff;

    // sum of the eight neighbours
    always_comb
    begin
        nsum_next = '0;
        for (int i = 0; i < WIN_TAPS; i++)
        begin
            if (i != CENTRE_TAP)
            begin
                nsum_next = nsum_next + SUM_W'(taps[i]);
            end
        end
    end

    // eight times centre minus neighbours, clamped to the channel range
    always_comb
    begin
        diff = $signed({1'b0, centre_reg, 3'b000}) - $signed({1'b0, nsum_reg});
        if (diff < 0)
        begin
            result_next = '0;
        end
        else if (diff > $signed(DIFF_W'(255)))
        begin
            result_next = '1;
        end
        else
        begin
            result_next = diff[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        nsum_reg   <= nsum_next;
        centre_reg <= taps[CENTRE_TAP];
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== rtl/core/lap3_out_queue.sv =====
module lap3_out_queue
    import lap3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    head_valid,
    output result_t head_data
);

    result_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH)) || do_pop)
        else $error("result queue overflow");

endmodule

// ===== rtl/core/laplacian_3x3_rgb_filter.sv =====
// 3x3 Laplacian (8-neighbour) filter on a raster-order RGB pixel stream. One pixel is taken
// per clock while in_stall is low; each pixel at column c, row r completes the window centred
// on (c-1, r-1) and, when that centre is interior, puts one result through the line buffer
// and the two lane stages into the result queue: 8*centre minus its eight neighbours per
// channel, clamped to 0..255, with the centre coordinates (low 10 bits) and frame_last on the
// last interior pixel. Border pixels give no result. Two line buffers of MAX_WIDTH pixels
// hold the rows above; the red, green and blue lanes run side by side and feed an 8-entry
// result queue, so in_stall rises only while 8 results are pending downstream. Writing
// image_width or image_height (saturated to 3..MAX_WIDTH / 3..MAX_HEIGHT) restarts the frame
// at column 0, row 0; write them only between frames with the pipeline drained.
module laplacian_3x3_rgb_filter
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CHAN_W-1:0]      in_red,
    input  logic [CHAN_W-1:0]      in_green,
    input  logic [CHAN_W-1:0]      in_blue,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAN_W-1:0]      out_red,
    output logic [CHAN_W-1:0]      out_green,
    output logic [CHAN_W-1:0]      out_blue,
    output logic [COORD_W-1:0]     centre_column,
    output logic [COORD_W-1:0]     centre_row,
    output logic                   frame_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ((CW > RW) ? CW : RW) + CFG_DATA_W + 1;
    localparam int LAST_COL_RST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;
    localparam int LAST_ROW_RST = ((RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT) - 1;

    logic [CW-1:0]          col_reg;
    logic [RW-1:0]          row_reg;
    logic [CW-1:0]          last_col_reg;
    logic [RW-1:0]          last_row_reg;
    logic [QUEUE_CNT_W-1:0] reserved_reg;
    logic [CMP_W-1:0]       cfg_wide;
    logic [CMP_W-1:0]       width_sat;
    logic [CMP_W-1:0]       height_sat;

    logic    accept;
    logic    cfg_write;
    logic    restart;
    logic    deliver;
    rgb_t    pixel;
    meta_t   meta_in;
    logic    win_valid;
    meta_t   win_meta;
    window_t window;
    logic    ma_valid_reg;
    meta_t   ma_meta_reg;
    logic    mb_valid_reg;
    meta_t   mb_meta_reg;
    rgb_t    lane_result;
    result_t push_data;
    result_t head_data;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign restart   = cfg_write
                       && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);
    assign accept    = in_valid && !in_stall;
    assign deliver   = out_valid && !out_stall;
    assign in_stall  = (reserved_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

    // saturate the written dimension
    always_comb
    begin
        cfg_wide = CMP_W'(cfg_data);
        if (cfg_wide < CMP_W'(MIN_DIM))
        begin
            width_sat  = CMP_W'(MIN_DIM);
            height_sat = CMP_W'(MIN_DIM);
        end
        else
        begin
            width_sat  = (cfg_wide > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : cfg_wide;
            height_sat = (cfg_wide > CMP_W'(MAX_HEIGHT)) ? CMP_W'(MAX_HEIGHT) : cfg_wide;
        end
    end

    assign pixel[0] = in_red;
    assign pixel[1] = in_green;
    assign pixel[2] = in_blue;

    always_comb
    begin
        meta_in.produce = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
        meta_in.col     = COORD_W'(col_reg - CW'(1));
        meta_in.row     = COORD_W'(row_reg - RW'(1));
        meta_in.last    = (col_reg == last_col_reg) && (row_reg == last_row_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= CW'(LAST_COL_RST);
            last_row_reg <= RW'(LAST_ROW_RST);
            reserved_reg <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_IMAGE_WIDTH)
            begin
                last_col_reg <= CW'(width_sat - CMP_W'(1));
            end
            if (cfg_write && cfg_index == REG_IMAGE_HEIGHT)
            begin
                last_row_reg <= RW'(height_sat - CMP_W'(1));
            end
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (accept)
            begin
                if (col_reg == last_col_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg == last_row_reg) ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if ((accept && meta_in.produce) && !deliver)
            begin
                reserved_reg <= reserved_reg + QUEUE_CNT_W'(1);
            end
            else if (!(accept && meta_in.produce) && deliver)
            begin
                reserved_reg <= reserved_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    lap3_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (accept),
        .col       (col_reg),
        .pixel     (pixel),
        .meta_in   (meta_in),
        .win_valid (win_valid),
        .win_meta  (win_meta),
        .window    (window)
    );

    for (genvar ch = 0; ch < NUM_CHAN; ch++)
    begin : g_lane
        taps_t taps;

        always_comb
        begin
            for (int i = 0; i < WIN_TAPS; i++)
            begin
                taps[i] = window[i][ch];
            end
        end

        lap3_lane u_lane (
            .clk    (clk),
            .taps   (taps),
            .result (lane_result[ch])
        );
    end

    // coordinates follow the two lane stages
    always_ff @(posedge clk)
    begin
        ma_meta_reg <= win_meta;
        mb_meta_reg <= ma_meta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ma_valid_reg <= 1'b0;
            mb_valid_reg <= 1'b0;
        end
        else
        begin
            ma_valid_reg <= win_valid && win_meta.produce;
            mb_valid_reg <= ma_valid_reg;
        end
    end

    // merge the lanes with their coordinates
    always_comb
    begin
        push_data.pixel = lane_result;
        push_data.col   = mb_meta_reg.col;
        push_data.row   = mb_meta_reg.row;
        push_data.last  = mb_meta_reg.last;
    end

    lap3_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (mb_valid_reg),
        .push_data  (push_data),
        .pop        (deliver),
        .head_valid (out_valid),
        .head_data  (head_data)
    );

    assign out_red       = head_data.pixel[0];
    assign out_green     = head_data.pixel[1];
    assign out_blue      = head_data.pixel[2];
    assign centre_column = head_data.col;
    assign centre_row    = head_data.row;
    assign frame_last    = head_data.last;

    reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserved_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result reservation count out of range");

    out_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reserved_reg != '0)
        else $error("result shown without a reservation");

    restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not restart the frame");

    no_transfer_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (reserved_reg == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> !accept)
        else $error("pixel transfer while result queue is reserved full");

endmodule
